// ----- rtl/contiguous_page_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the page allocator engine
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_pkg
// Item types and status codes of the contiguous page allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_RUN  = 2'd1;
  localparam logic [1:0] STATUS_BAD_REQ = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [21:0] request_bytes;
    logic [31:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] address;
    logic [1:0]  status;
    logic [9:0]  used_units;
  } out_item_t;

endpackage

// ----- rtl/cpa_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_engine
// Sequencer over the run-mark memory: clearing pass, first-fit scan, run
// marking and run release, one memory entry per cycle through one
// address counter and one mark adder.
// ----------------------------------------------------------------------------
module cpa_engine #(
  parameter int UNIT_COUNT = 512,
  parameter int UNIT_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  cpa_pkg::in_item_t item,
  input  logic [31:0]       base_addr,
  output logic              busy,
  output logic              res_valid,
  output cpa_pkg::out_item_t res
);
  import cpa_pkg::*;
  `include "contiguous_page_allocator_macros.svh"

  localparam int UW    = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;
  localparam int MW    = $clog2(UNIT_COUNT + 1);
  localparam int SHIFT = $clog2(UNIT_BYTES);
  localparam logic [UW-1:0] LAST_UNIT  = UW'(UNIT_COUNT - 1);
  localparam logic [MW-1:0] COUNT_MAX  = MW'(UNIT_COUNT);
  localparam logic [22:0]   ROUND_ADD  = 23'(UNIT_BYTES - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_MARK  = 6'b001000,
    ST_FHEAD = 6'b010000,
    ST_FCLR  = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [UW-1:0]   addr_r, addr_nxt;
  logic [UW-1:0]   start_r, start_nxt;
  logic [MW-1:0]   len_r, len_nxt;
  logic [MW-1:0]   units_r, units_nxt;
  logic [MW-1:0]   rem_r, rem_nxt;
  logic [MW-1:0]   used_r, used_nxt;

  logic [MW-1:0]   mark_mem [UNIT_COUNT];
  logic [MW-1:0]   rd_data_r;
  logic            we;
  logic [MW-1:0]   wdata;

  logic [22:0]     alloc_units;
  logic [31:0]     free_offset;
  logic [31:0]     free_unit;
  logic [MW-1:0]   len_inc;
  logic [1:0]      res_status;
  logic [31:0]     res_address;

  always_comb begin
    alloc_units = (23'(item.request_bytes) + ROUND_ADD) >> SHIFT;
    free_offset = item.free_address - base_addr;
    free_unit   = free_offset >> SHIFT;
    len_inc     = len_r + MW'(1);

    state_nxt   = state_r;
    addr_nxt    = addr_r;
    start_nxt   = start_r;
    len_nxt     = len_r;
    units_nxt   = units_r;
    rem_nxt     = rem_r;
    used_nxt    = used_r;
    we          = 1'b0;
    wdata       = '0;
    res_valid   = 1'b0;
    res_status  = STATUS_OK;
    res_address = '0;

    case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        if (addr_r == LAST_UNIT) begin
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + UW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (item.operation == OP_ALLOC) begin
            if (alloc_units == '0) begin
              res_valid  = 1'b1;
              res_status = STATUS_BAD_REQ;
            end else if (alloc_units > 23'(UNIT_COUNT)) begin
              res_valid  = 1'b1;
              res_status = STATUS_NO_RUN;
            end else begin
              units_nxt = MW'(alloc_units);
              len_nxt   = '0;
              addr_nxt  = '0;
              state_nxt = ST_SCAN;
            end
          end else begin
            if (free_unit >= 32'(UNIT_COUNT)) begin
              res_valid  = 1'b1;
              res_status = STATUS_BAD_REQ;
            end else begin
              addr_nxt  = UW'(free_unit);
              state_nxt = ST_FHEAD;
            end
          end
        end
      end
      ST_SCAN: begin
        if (rd_data_r != '0) begin
          len_nxt = '0;
        end else begin
          if (len_r == '0) begin
            start_nxt = addr_r;
          end
          len_nxt = len_inc;
        end
        if (rd_data_r == '0 && len_inc == units_r) begin
          // run found: rewind to its first unit and mark upwards with descending counts
          addr_nxt  = (len_r == '0) ? addr_r : start_r;
          rem_nxt   = units_r;
          state_nxt = ST_MARK;
        end else if (addr_r == LAST_UNIT) begin
          res_valid  = 1'b1;
          res_status = STATUS_NO_RUN;
          state_nxt  = ST_IDLE;
        end else begin
          addr_nxt = addr_r + UW'(1);
        end
      end
      ST_MARK: begin
        we      = 1'b1;
        wdata   = rem_r;
        rem_nxt = rem_r - MW'(1);
        if (rem_r == MW'(1)) begin
          used_nxt    = used_r + units_r;
          res_valid   = 1'b1;
          res_address = base_addr + (32'(start_r) << SHIFT);
          state_nxt   = ST_IDLE;
        end else begin
          addr_nxt = addr_r + UW'(1);
        end
      end
      ST_FHEAD: begin
        if (rd_data_r == '0) begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          we       = 1'b1;
          used_nxt = used_r - MW'(1);
          rem_nxt  = rd_data_r - MW'(1);
          if (rd_data_r == MW'(1) || addr_r == LAST_UNIT) begin
            res_valid = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            addr_nxt  = addr_r + UW'(1);
            state_nxt = ST_FCLR;
          end
        end
      end
      ST_FCLR: begin
        // units already free inside the span are skipped, not counted
        if (rd_data_r != '0) begin
          we       = 1'b1;
          used_nxt = used_r - MW'(1);
        end
        rem_nxt = rem_r - MW'(1);
        if (rem_r == MW'(1) || addr_r == LAST_UNIT) begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + UW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      addr_r  <= '0;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      used_r  <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    len_r   <= len_nxt;
    units_r <= units_nxt;
    rem_r   <= rem_nxt;
  end

  // read the entry that addr_r will point at, so rd_data_r tracks addr_r
  always_ff @(posedge clk) begin
    if (we) begin
      mark_mem[addr_r] <= wdata;
    end
    rd_data_r <= mark_mem[addr_nxt];
  end

  assign busy           = (state_r != ST_IDLE);
  assign res.address    = res_address;
  assign res.status     = res_status;
  assign res.used_units = 10'(used_nxt);

  `CPA_ASSERT_NOW(a_used_bound, 1'b1, used_r <= COUNT_MAX, "used count beyond map size")
  `CPA_ASSERT_NEXT(a_done_idle, res_valid, state_r == ST_IDLE, "not idle after result")
  `CPA_ASSERT_NOW(a_mark_nonzero, state_r == ST_MARK, wdata != '0, "zero mark written in run")
  `CPA_ASSERT_NOW(a_clear_quiet, state_r == ST_CLEAR, !res_valid, "result during clearing pass")

endmodule

// ----- rtl/contiguous_page_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_page_allocator
// First-fit allocator of contiguous runs of fixed-size units.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_item and raise start; the item is taken at a clock edge
//   with start high and busy low. operation selects allocate or free.
//   Result: out_item is valid for exactly one cycle, marked by out_strobe.
//   The receiver cannot stall; every result must be taken in that cycle.
//   Configuration: cfg_we with cfg_wdata writes the buffer base address;
//   write it only while the block is idle.
// Sequence from accept to result, one mark read or write per cycle:
//   rejected request (zero size, too large, bad free address): answered
//     from the idle state, with no mark memory access.
//   allocate: first-fit scan of up to UNIT_COUNT units, then run marking.
//   free: clears the run from the given unit; only its head mark is read
//     when the unit is already free.
//   One item at a time; busy stays high until the result is produced.
// Reset: rst_n (synchronous, active low) starts a clearing pass over all
//   UNIT_COUNT units that zeroes every mark; busy is high throughout.
// ----------------------------------------------------------------------------
module contiguous_page_allocator #(
  parameter int UNIT_COUNT = 512,
  parameter int UNIT_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cpa_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output cpa_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);
  import cpa_pkg::*;

  logic [31:0] base_addr_r;
  logic        out_strobe_r;
  out_item_t   out_item_r;
  logic        eng_busy;
  logic        accept;
  logic        res_valid;
  out_item_t   res;

  assign accept = start & ~eng_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_addr_r <= '0;
    end else if (cfg_we) begin
      base_addr_r <= cfg_wdata;
    end
  end

  cpa_engine #(
    .UNIT_COUNT (UNIT_COUNT),
    .UNIT_BYTES (UNIT_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_item),
    .base_addr (base_addr_r),
    .busy      (eng_busy),
    .res_valid (res_valid),
    .res       (res)
  );

  // raise out_strobe for one cycle per engine result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_item_r <= res;
    end
  end

  assign busy       = eng_busy;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule
